/* src/molecule_gap_capture_tracker_defines.svh */
// Assertion helpers for the gap capture tracker
`ifndef MOLECULE_GAP_CAPTURE_TRACKER_DEFINES_SVH
`define MOLECULE_GAP_CAPTURE_TRACKER_DEFINES_SVH
`define MGCT_ASSERT_IMP(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("same-cycle check failed");
`define MGCT_ASSERT_NXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("next-cycle check failed");
`endif

/* src/mgct_pkg.sv */
//------------------------------------------------------------------------------
// mgct_pkg
// Types and constants shared by the gap capture tracker.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package mgct_pkg;
  localparam int IonAtomsMax  = 256;
  localparam int TypeCount    = 8;
  localparam int MoleculesMax = 1024;
  localparam int SlotW = $clog2(IonAtomsMax);
  localparam int TypeW = $clog2(TypeCount);
  localparam int MolW  = $clog2(MoleculesMax);
  localparam logic [30:0] Root6Q30 = 31'd1205234447;
  localparam logic signed [31:0] GapMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] GapMin = 32'sh8000_0000;

  localparam logic [1:0] FUNC_ION  = 2'd0;
  localparam logic [1:0] FUNC_VAP  = 2'd1;
  localparam logic [1:0] FUNC_SIZE = 2'd2;
  localparam logic [1:0] CFG_ARRIVE = 2'd0;
  localparam logic [1:0] CFG_LEAVE  = 2'd1;
  localparam logic [1:0] CFG_COUNT  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic [7:0]         ion_slot;
    logic [9:0]         molecule_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [2:0]         atom_type;
    logic               first_atom;
    logic               last_atom;
    logic [30:0]        type_size;
    logic [31:0]        time_stamp;
  } in_req_t;

  typedef struct packed {
    logic [9:0]         out_molecule;
    logic signed [31:0] min_gap;
    logic [7:0]         nearest_ion_atom;
    logic               nearest_valid;
    logic               was_bound;
    logic               now_bound;
    logic [31:0]        out_time;
  } out_req_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_RD, ST_DIFF, ST_SQ, ST_SUM, ST_SQRT, ST_GAP, ST_CMP,
    ST_FLAG_RD, ST_FLAG_WAIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;      // latch request
    logic write_ion;
    logic write_size;
    logic restart;
    logic clr_slot;
    logic inc_slot;
    logic rd;
    logic diff;
    logic sq;
    logic sum;
    logic sqrt_start;
    logic gap;
    logic cmp;
    logic clr_flag;
    logic flag_rd;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic last_slot;
    logic no_atoms;
    logic sqrt_done;
    logic clear_done;
  } sts_t;
endpackage

/* src/mgct_ram.sv */
//------------------------------------------------------------------------------
// mgct_ram
// Generic single-port RAM with registered read.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mgct_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* src/mgct_datapath.sv */
//------------------------------------------------------------------------------
// mgct_datapath
// Ion stores, pair gap arithmetic, running minimum and binding flags.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mgct_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  mgct_pkg::in_req_t  in_req,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_data,
  input  mgct_pkg::ctl_t     ctl,
  output mgct_pkg::sts_t     sts,
  output mgct_pkg::out_req_t res
);
  import mgct_pkg::*;

  logic signed [31:0] arrive_r, leave_r;
  logic [8:0]         count_r;
  in_req_t            req_r;
  logic [SlotW:0]     slot_r;
  logic [MolW:0]      clr_r;
  logic [30:0]        size_r [TypeCount];
  logic signed [31:0] min_r;
  logic [SlotW-1:0]   near_r;
  logic               nvalid_r;
  logic [32:0]        ax_r, ay_r, az_r;
  logic [65:0]        sx_r, sy_r, sz_r, sum_r;
  logic [65:0]        rem_r;
  logic [32:0]        root_r;
  logic [5:0]         it_r;
  logic               sq_busy_r;
  logic signed [31:0] gap_r;
  logic               was_r;

  logic [31:0] rx, ry, rz;
  logic [2:0]  rt;
  logic [SlotW-1:0] addr;
  logic        ram_we;
  logic [MolW-1:0] faddr;
  logic        fwe, fwd, frd;
  logic [SlotW:0] nlim;

  assign ram_we = ctl.write_ion && req_r.ion_slot < IonAtomsMax;
  assign addr   = ctl.write_ion ? req_r.ion_slot[SlotW-1:0] : slot_r[SlotW-1:0];

  mgct_ram #(.Width(32), .Depth(IonAtomsMax)) u_x (.clk, .we(ram_we), .addr,
    .wdata(req_r.pos_x), .rdata(rx));
  mgct_ram #(.Width(32), .Depth(IonAtomsMax)) u_y (.clk, .we(ram_we), .addr,
    .wdata(req_r.pos_y), .rdata(ry));
  mgct_ram #(.Width(32), .Depth(IonAtomsMax)) u_z (.clk, .we(ram_we), .addr,
    .wdata(req_r.pos_z), .rdata(rz));
  mgct_ram #(.Width(3), .Depth(IonAtomsMax)) u_t (.clk, .we(ram_we), .addr,
    .wdata(req_r.atom_type), .rdata(rt));

  // binding flags: cleared by a sweep after reset
  logic now_b;
  assign fwe   = ctl.clr_flag || (ctl.emit && req_r.molecule_id < MoleculesMax);
  assign fwd   = ctl.clr_flag ? 1'b0 : now_b;
  assign faddr = ctl.clr_flag ? clr_r[MolW-1:0] : req_r.molecule_id[MolW-1:0];
  mgct_ram #(.Width(1), .Depth(MoleculesMax)) u_f (.clk, .we(fwe), .addr(faddr),
    .wdata(fwd), .rdata(frd));

  assign nlim = (count_r > IonAtomsMax) ? (SlotW+1)'(IonAtomsMax) : count_r[SlotW:0];
  assign sts.last_slot  = (slot_r + 1'b1) >= nlim;
  assign sts.no_atoms   = (nlim == '0);
  assign sts.sqrt_done  = !sq_busy_r;
  assign sts.clear_done = (clr_r == (MolW+1)'(MoleculesMax - 1));

  function automatic logic [32:0] absd(input logic [31:0] a, input logic [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic [65:0] trial;
  logic [65:0] rem_sh;
  assign rem_sh = {rem_r[63:0], sum_r[65:64]};
  assign trial  = {31'd0, root_r, 2'b01};

  logic [31:0] vsize, isize;
  logic [31:0] ssum;
  logic [62:0] sprod;
  logic signed [34:0] g;
  assign vsize = (req_r.atom_type < TypeCount) ? {1'b0, size_r[req_r.atom_type]} : '0;
  assign isize = {1'b0, size_r[rt]};
  assign ssum  = vsize + isize;
  assign sprod = ssum * Root6Q30;
  assign g = $signed({2'b0, root_r}) - $signed({3'b0, sprod[62:31]});

  logic was_c;
  assign was_c = (req_r.molecule_id < MoleculesMax) ? frd : 1'b0;
  assign now_b = was_r ? !(min_r > leave_r) : (min_r < arrive_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arrive_r <= '0;
      leave_r  <= '0;
      count_r  <= '0;
      min_r    <= GapMax;
      near_r   <= '0;
      nvalid_r <= 1'b0;
      sq_busy_r <= 1'b0;
      clr_r    <= '0;
      slot_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_ARRIVE: arrive_r <= cfg_data;
          CFG_LEAVE:  leave_r  <= cfg_data;
          CFG_COUNT:  count_r  <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (ctl.clr_flag) clr_r <= clr_r + 1'b1;
      if (ctl.clr_slot) slot_r <= '0;
      else if (ctl.inc_slot) slot_r <= slot_r + 1'b1;
      if (ctl.restart || ctl.emit) begin
        min_r <= GapMax; near_r <= '0; nvalid_r <= 1'b0;
      end else if (ctl.cmp && gap_r < min_r) begin
        min_r <= gap_r; near_r <= slot_r[SlotW-1:0]; nvalid_r <= 1'b1;
      end
      if (ctl.sum) sum_r <= sx_r + sy_r + sz_r;
      if (ctl.sqrt_start) begin
        sq_busy_r <= 1'b1;
        it_r <= '0;
        rem_r <= '0;
        root_r <= '0;
      end else if (sq_busy_r) begin
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[31:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[31:0], 1'b0};
        end
        sum_r <= {sum_r[63:0], 2'b00};
        it_r  <= it_r + 1'b1;
        if (it_r == 6'd32) sq_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) req_r <= in_req;
    if (ctl.write_size && req_r.atom_type < TypeCount)
      size_r[req_r.atom_type] <= req_r.type_size;
    if (ctl.diff) begin
      ax_r <= absd(req_r.pos_x, rx);
      ay_r <= absd(req_r.pos_y, ry);
      az_r <= absd(req_r.pos_z, rz);
    end
    if (ctl.sq) begin
      sx_r <= ax_r * ax_r;
      sy_r <= ay_r * ay_r;
      sz_r <= az_r * az_r;
    end
    if (ctl.gap) begin
      gap_r <= (g > 35'sh7FFF_FFFF) ? GapMax :
               (g < 35'sh7_8000_0000) ? GapMin : g[31:0];
    end
    if (ctl.flag_rd) was_r <= was_c;
  end

  assign res.out_molecule     = req_r.molecule_id;
  assign res.min_gap          = min_r;
  assign res.nearest_ion_atom = nvalid_r ? 8'(near_r) : 8'd0;
  assign res.nearest_valid    = nvalid_r;
  assign res.was_bound        = was_r;
  assign res.now_bound        = now_b;
  assign res.out_time         = req_r.time_stamp;
endmodule

/* src/mgct_ctrl.sv */
//------------------------------------------------------------------------------
// mgct_ctrl
// Sequencer for loads, the per-slot gap loop and the result step.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module mgct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [1:0]     func,
  input  logic           first_atom,
  input  logic           last_atom,
  input  mgct_pkg::sts_t sts,
  output mgct_pkg::ctl_t ctl,
  output logic           busy,
  output logic           out_strobe
);
  import mgct_pkg::*;
  `include "molecule_gap_capture_tracker_defines.svh"

  state_t state_r, state_nxt;
  logic [1:0] func_r;
  logic last_r;
  logic sq_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      func_r  <= FUNC_ION;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start && !busy) begin
        func_r <= func;
        last_r <= last_atom;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clear_done) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start && func == FUNC_VAP) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (sts.no_atoms) state_nxt = last_r ? ST_FLAG_RD : ST_IDLE;
        else state_nxt = ST_DIFF;
      end
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_SQRT;
      // the root unit reports busy only from the cycle after its start
      ST_SQRT: if (sts.sqrt_done && !sq_go) state_nxt = ST_GAP;
      ST_GAP:  state_nxt = ST_CMP;
      ST_CMP: begin
        if (!sts.last_slot) state_nxt = ST_RD;
        else state_nxt = last_r ? ST_FLAG_RD : ST_IDLE;
      end
      ST_FLAG_RD:   state_nxt = ST_FLAG_WAIT;
      ST_FLAG_WAIT: state_nxt = ST_EMIT;
      ST_EMIT:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_go <= 1'b0;
    else sq_go <= (state_r == ST_SUM);
  end

  always_comb begin
    ctl = '0;
    busy = (state_r != ST_IDLE);
    out_strobe = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctl.load = start;
        ctl.restart = start && func == FUNC_VAP && first_atom;
        ctl.clr_slot = 1'b1;
      end
      ST_CLEAR: ctl.clr_flag = 1'b1;
      ST_RD:    ctl.rd = 1'b1;
      ST_DIFF:  ctl.diff = 1'b1;
      ST_SQ:    ctl.sq = 1'b1;
      ST_SUM:   ctl.sum = 1'b1;
      ST_SQRT:  ctl.sqrt_start = sq_go;
      ST_GAP:   ctl.gap = 1'b1;
      ST_CMP: begin
        ctl.cmp = 1'b1;
        ctl.inc_slot = 1'b1;
      end
      ST_FLAG_WAIT: ctl.flag_rd = 1'b1;
      ST_EMIT: begin
        ctl.emit = 1'b1;
        out_strobe = 1'b1;
      end
      default: ;
    endcase
  end

  `MGCT_ASSERT_NXT(a_emit_idle, state_r == ST_EMIT, state_r == ST_IDLE)
  `MGCT_ASSERT_IMP(a_strobe_last, out_strobe, last_r && func_r == FUNC_VAP)
  `MGCT_ASSERT_IMP(a_cmp_busy, state_r == ST_CMP, busy)
  `MGCT_ASSERT_NXT(a_sqrt_go, state_r == ST_SUM, state_r == ST_SQRT)
endmodule

/* src/molecule_gap_capture_tracker.sv */
// Gap capture tracker top level.
// A load request is latched, then written in the next cycle; busy stays low.
// A vapor atom holds busy: per ion atom read, diff, square, sum, root, gap, compare
// (only a read with none); a last atom adds flag read, wait and emit, strobed in emit.
// Throughput: one request at a time, set by the per-slot loop; results cannot stall.
// Reset: synchronous; a flag clearing pass over all molecules follows, busy held high.
//------------------------------------------------------------------------------
// molecule_gap_capture_tracker
// Ties sequencer and datapath to the request, result and config ports.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module molecule_gap_capture_tracker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mgct_pkg::in_req_t  in_req,
  output logic               out_strobe,
  output mgct_pkg::out_req_t out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import mgct_pkg::*;

  ctl_t ctl, ctl_m;
  sts_t sts;
  logic wr_pend_r;
  logic [1:0] func_r;

  mgct_ctrl u_ctrl (
    .clk, .rst_n, .start, .func(in_req.func), .first_atom(in_req.first_atom),
    .last_atom(in_req.last_atom), .sts, .ctl, .busy, .out_strobe
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
      func_r <= FUNC_ION;
    end else begin
      wr_pend_r <= start && !busy;
      if (start && !busy) func_r <= in_req.func;
    end
  end

  always_comb begin
    ctl_m = ctl;
    ctl_m.write_ion  = wr_pend_r && func_r == FUNC_ION;
    ctl_m.write_size = wr_pend_r && func_r == FUNC_SIZE;
  end

  assign cfg_ready = 1'b1;

  mgct_datapath u_dp (
    .clk, .rst_n, .in_req, .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index),
    .cfg_data, .ctl(ctl_m), .sts, .res(out_res)
  );
endmodule
